// File: hw/rtl/tsp_pkg.sv
// Shared types and constants for the tone sequence player.
`default_nettype none

package tsp_pkg;

	localparam int unsigned TableDepthDef = 16;

	localparam int unsigned SlotW  = 4;
	localparam int unsigned FreqW  = 16;
	localparam int unsigned DurW   = 16;
	localparam int unsigned IdxW   = 5;
	localparam int unsigned StateW = 2;

	localparam logic [StateW-1:0] ST_IDLE = 2'd0;
	localparam logic [StateW-1:0] ST_PLAY = 2'd1;
	localparam logic [StateW-1:0] ST_STOP = 2'd2;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic [FreqW-1:0] freq;
		logic [DurW-1:0]  dur;
	} tsp_note_t;

	typedef struct packed {
		logic             en;
		logic [SlotW-1:0] slot;
		tsp_note_t        note;
	} tsp_wr_t;

endpackage

`default_nettype wire

// File: hw/rtl/tsp_note_mem.sv
// Note table memory with a registered read and write-to-read forwarding.
`default_nettype none

module tsp_note_mem import tsp_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire tsp_wr_t          wr,
	input  wire logic [IdxW-1:0]  rd_idx,
	output      tsp_note_t        note
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	tsp_note_t mem [TABLE_DEPTH];

	logic [AW+IdxW-1:0]  rd_wide;
	logic [AW+SlotW-1:0] wr_wide;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;
	logic                rd_ok;
	logic                wr_ok;
	logic                fwd;

	tsp_note_t rd_data_s1;
	tsp_note_t fwd_data_s1;
	logic      fwd_s1;
	logic      rd_ok_s1;

	assign rd_wide = (AW + IdxW)'(rd_idx);
	assign wr_wide = (AW + SlotW)'(wr.slot);
	assign rd_ok   = 32'(rd_idx) < TABLE_DEPTH;
	assign wr_ok   = wr.en && (32'(wr.slot) < TABLE_DEPTH);
	assign rd_addr = rd_ok ? rd_wide[AW-1:0] : '0;
	assign wr_addr = wr_wide[AW-1:0];
	// A write in the same cycle as the read of that entry returns the new data.
	assign fwd     = wr_ok && rd_ok && (wr_addr == rd_addr);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[wr_addr] <= wr.note;
		end
		rd_data_s1  <= mem[rd_addr];
		fwd_data_s1 <= wr.note;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_s1   <= 1'b0;
			rd_ok_s1 <= 1'b0;
		end else begin
			fwd_s1   <= fwd;
			rd_ok_s1 <= rd_ok;
		end
	end

	always_comb begin
		if (!rd_ok_s1) begin
			note = '0;
		end else if (fwd_s1) begin
			note = fwd_data_s1;
		end else begin
			note = rd_data_s1;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/tsp_player.sv
// Player state machine: note index, tick counter and per-item result.
`default_nettype none

module tsp_player import tsp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic              op,
	input  wire logic [IdxW-1:0]   seq_len,
	input  wire logic              loop_mode,
	input  wire tsp_note_t         note,
	output      logic [IdxW-1:0]   rd_idx,
	output      logic              res_update,
	output      logic [FreqW-1:0]  res_freq,
	output      logic [StateW-1:0] res_state
);

	logic [StateW-1:0] state_q;
	logic [IdxW-1:0]   note_index_q;
	logic [DurW-1:0]   tick_count_q;

	logic [StateW-1:0] state_d;
	logic [IdxW-1:0]   index_d;
	logic [DurW-1:0]   tick_d;
	logic [DurW-1:0]   tick_inc;
	logic [IdxW-1:0]   index_adv;

	assign tick_inc  = tick_count_q + 1'b1;
	assign index_adv = (tick_inc >= note.dur) ? note_index_q + 1'b1 : note_index_q;

	always_comb begin
		state_d    = state_q;
		index_d    = note_index_q;
		tick_d     = tick_count_q;
		res_update = 1'b0;
		res_freq   = '0;
		if (op == OP_TICK) begin
			unique case (state_q)
				ST_IDLE: begin
					index_d = '0;
					tick_d  = '0;
					state_d = ST_PLAY;
				end
				ST_PLAY: begin
					res_update = 1'b1;
					res_freq   = note.freq;
					index_d    = index_adv;
					tick_d     = (tick_inc >= note.dur) ? '0 : tick_inc;
					if (index_adv >= seq_len) begin
						state_d = (loop_mode || index_adv != seq_len) ? ST_IDLE : ST_STOP;
					end
				end
				default: begin
					res_update = 1'b1;
					if (note_index_q != seq_len) begin
						state_d = ST_IDLE;
					end
				end
			endcase
		end
	end

	assign res_state = state_d;
	// The table is always read at the index the next item will see.
	assign rd_idx    = accept ? index_d : note_index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			note_index_q <= '0;
			tick_count_q <= '0;
		end else if (accept) begin
			state_q      <= state_d;
			note_index_q <= index_d;
			tick_count_q <= tick_d;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/tone_sequence_player.sv
// Tone sequence player: one tick or one note write per cycle while the input is not stalled.
// A result is presented in the cycle after its item's transfer.
// Throughput: one item per cycle when not stalled; the note table read for the next item is issued as an item is taken.
// The input stalls only while a presented result is itself stalled.
// Reset puts the player in idle at note 0; the note table is not cleared.
`default_nettype none

module tone_sequence_player import tsp_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_stall,
	input  wire logic              op,
	input  wire logic [SlotW-1:0]  entry_slot,
	input  wire logic [FreqW-1:0]  entry_freq,
	input  wire logic [DurW-1:0]   entry_duration,
	input  wire logic [IdxW-1:0]   seq_len,
	input  wire logic              loop_mode,
	output      logic              out_valid,
	input  wire logic              out_stall,
	output      logic              freq_update,
	output      logic [FreqW-1:0]  tone_freq,
	output      logic [StateW-1:0] player_state
);

	logic              in_fire;
	tsp_wr_t           wr;
	tsp_note_t         note;
	logic [IdxW-1:0]   rd_idx;
	logic              res_update;
	logic [FreqW-1:0]  res_freq;
	logic [StateW-1:0] res_state;

	logic              out_valid_q;
	logic              freq_update_q;
	logic [FreqW-1:0]  tone_freq_q;
	logic [StateW-1:0] player_state_q;

	assign in_stall = out_valid_q && out_stall;
	assign in_fire  = in_valid && !in_stall;

	assign wr.en        = in_fire && (op == OP_WRITE);
	assign wr.slot      = entry_slot;
	assign wr.note.freq = entry_freq;
	assign wr.note.dur  = entry_duration;

	tsp_note_mem #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd_idx (rd_idx),
		.note   (note)
	);

	tsp_player u_player (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_fire),
		.op         (op),
		.seq_len    (seq_len),
		.loop_mode  (loop_mode),
		.note       (note),
		.rd_idx     (rd_idx),
		.res_update (res_update),
		.res_freq   (res_freq),
		.res_state  (res_state)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			freq_update_q  <= res_update;
			tone_freq_q    <= res_freq;
			player_state_q <= res_state;
		end
	end

	assign out_valid    = out_valid_q;
	assign freq_update  = freq_update_q;
	assign tone_freq    = tone_freq_q;
	assign player_state = player_state_q;

	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid)
		else $error("accepted item produced no result");

	a_silent_without_update: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (freq_update || tone_freq == '0))
		else $error("frequency driven without update");

	a_write_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && op == OP_WRITE) |-> res_state == u_player.state_q)
		else $error("table write changed the player state");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && $past(in_fire || out_valid))
		else $error("input stalled with no pending result");

endmodule

`default_nettype wire
